@@ src/etg_pkg.sv @@
// ----------------------------------------------------------------------------
// etg_pkg: shared types and constants of the eased tween generator
// Easing mode codes, sequencer states and the functions that fill the tables.
// ----------------------------------------------------------------------------
package etg_pkg;

    typedef enum logic [2:0] {
        MODE_LINEAR  = 3'd0,
        MODE_IN      = 3'd1,
        MODE_OUT     = 3'd2,
        MODE_INOUT   = 3'd3,
        MODE_BOUNCE  = 3'd4,
        MODE_ELASTIC = 3'd5
    } ease_mode_t;

    localparam logic CFG_DURATION = 1'b0;
    localparam logic CFG_MODE     = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_DIV,
        ST_SETUP,
        ST_MUL,
        ST_FINISH,
        ST_OUT
    } seq_state_t;

    localparam logic [63:0] PI_Q28  = 64'd843314857;
    localparam logic [63:0] LN2_Q28 = 64'd186065280;

    // Table contents, evaluated at elaboration only.
    function automatic logic signed [16:0] sine_entry(input int unsigned i,
                                                      input int unsigned d);
        logic [63:0] x, term, mag;
        logic signed [63:0] sum;
        logic neg;
        x = (64'd2 * PI_Q28 * 64'(i) + 64'(d / 2)) / 64'(d);
        neg = 1'b0;
        if (x > PI_Q28) begin
            x = x - PI_Q28;
            neg = 1'b1;
        end
        sum = $signed(x);
        term = x;
        for (int n = 1; n <= 12; n++) begin
            term = ((term * x) >> 28) / 64'(2 * n);
            term = ((term * x) >> 28) / 64'(2 * n + 1);
            if (n % 2 == 1) sum = sum - $signed(term);
            else sum = sum + $signed(term);
        end
        if (sum < 0) sum = 0;
        mag = (64'(sum) + 64'd4096) >> 13;
        if (mag > 64'd32767) mag = 64'd32767;
        return neg ? -$signed({1'b0, mag[15:0]}) : $signed({1'b0, mag[15:0]});
    endfunction

    function automatic logic [16:0] exp_entry(input int unsigned i,
                                              input int unsigned d);
        logic [63:0] y, term;
        logic signed [63:0] sum;
        y = (LN2_Q28 * 64'(i)) / 64'(d);
        term = 64'd1 << 28;
        sum = $signed(term);
        for (int n = 1; n <= 16; n++) begin
            term = ((term * y) >> 28) / 64'(n);
            if (n % 2 == 1) sum = sum - $signed(term);
            else sum = sum + $signed(term);
        end
        if (sum < 0) sum = 0;
        return 17'((64'(sum) + 64'd2048) >> 12);
    endfunction

endpackage

@@ src/etg_divider.sv @@
// ----------------------------------------------------------------------------
// etg_divider: restoring divider, one quotient bit per cycle
// Computes floor((num << 16) / den) for num < den, 16 quotient bits.
// ----------------------------------------------------------------------------
module etg_divider #(
    parameter int TIME_WIDTH = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [TIME_WIDTH-1:0] num,
    input  logic [15:0]           den,
    output logic                  busy,
    output logic [15:0]           quo
);
    import etg_pkg::*;

    logic [16:0] rem_reg, rem_next;
    logic [15:0] quo_reg, quo_next;
    logic [15:0] den_reg;
    logic [4:0]  cnt_reg, cnt_next;
    logic [16:0] trial;

    assign busy = (cnt_reg != 5'd0);
    assign quo  = quo_reg;
    assign trial = {rem_reg[15:0], 1'b0};

    always_comb begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        if (start) begin
            // num < den here, so it fits in 16 bits
            rem_next = {1'b0, 16'(num)};
            quo_next = '0;
            cnt_next = 5'd16;
        end else if (busy) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = trial - {1'b0, den_reg};
                quo_next = {quo_reg[14:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[14:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start) den_reg <= den;
    end
endmodule

@@ src/etg_curve.sv @@
// ----------------------------------------------------------------------------
// etg_curve: easing curve evaluation around one shared multiplier
// One multiply pass; tables read in the setup cycle.
// ----------------------------------------------------------------------------
module etg_curve #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        setup,
    input  logic        mul,
    input  logic        finish,
    input  logic [2:0]  mode,
    input  logic [16:0] prog,
    output logic [15:0] eased
);
    import etg_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    logic signed [16:0] sine_rom [TABLE_DEPTH];
    logic [16:0]        exp_rom  [TABLE_DEPTH];

    logic signed [23:0] opa_reg, opb_reg;
    logic signed [23:0] opa_next, opb_next;
    logic [37:0]        add_reg, add_next;
    logic signed [47:0] prod_reg;
    logic [2:0]         mode_q;
    logic [15:0]        eased_reg;
    logic [15:0]        eased_comb;
    logic               is_zero, is_one, last_piece;

    // elastic pieces
    logic [20:0] tenp;
    logic [3:0]  kk;
    logic [AW-1:0] ei, si;
    logic [16:0] amp;
    logic [23:0] ph;
    logic [16:0] phd;
    logic [16:0] phq;
    // bounce pieces
    logic signed [21:0] e, dd;
    logic signed [22:0] d4;

    logic [72:0] num;
    logic [73:0] rnd;
    logic signed [72:0] q;
    logic signed [72:0] val;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_rom
        assign sine_rom[g] = sine_entry(g, TABLE_DEPTH);
        assign exp_rom[g]  = exp_entry(g, TABLE_DEPTH);
    end

    assign tenp = 21'(prog) * 21'd10;
    assign kk   = tenp[19:16];
    assign ei   = AW'((32'(tenp[15:0]) * 32'(TABLE_DEPTH)) >> 16);
    assign amp  = exp_rom[ei] >> kk;
    assign ph   = 24'(prog) * 24'd40 + 24'd589824;
    // ph*D / 786432 = (ph*D >> 18) / 3; that stays below 2^16, so x/3 = x*43691 >> 17
    assign phd  = 17'(((32 + AW)'(ph) * (32 + AW)'(TABLE_DEPTH)) >> 18);
    assign phq  = 17'((34'(phd) * 34'd43691) >> 17);
    assign si   = phq[AW-1:0];
    assign e    = 22'(prog) * 22'sd11;
    // bounce last piece uses (2e-21)^2 directly
    assign d4   = $signed({e, 1'b0}) - 23'sd1376256;

    assign is_zero    = (prog == 17'd0);
    assign is_one     = prog[16];
    assign last_piece = (e >= 22'sd655360);

    always_comb begin
        opa_next = '0;
        opb_next = '0;
        add_next = '0;
        dd = '0;
        unique case (mode)
            MODE_IN: begin
                opa_next = 24'(prog); opb_next = 24'(prog);
            end
            MODE_OUT: begin
                opa_next = 24'(prog); opb_next = $signed(24'd131072 - 24'(prog));
            end
            MODE_INOUT: begin
                if (prog < 17'd32768) begin
                    opa_next = 24'(prog); opb_next = 24'({prog, 1'b0});
                end else begin
                    opa_next = 24'({prog, 1'b0});
                    opb_next = $signed(24'd131072 - 24'(prog));
                end
            end
            MODE_BOUNCE: begin
                if (e < 22'sd262144) begin
                    dd = e;
                end else if (e < 22'sd524288) begin
                    dd = e - 22'sd393216; add_next = 38'd3 << 36;
                end else if (e < 22'sd655360) begin
                    dd = e - 22'sd589824; add_next = 38'd15 << 34;
                end else begin
                    add_next = 38'd63 << 32;
                end
                if (last_piece) begin
                    opa_next = 24'(d4); opb_next = 24'(d4);
                end else begin
                    opa_next = 24'(dd); opb_next = 24'(dd);
                end
            end
            MODE_ELASTIC: begin
                opa_next = 24'(amp); opb_next = 24'(sine_rom[si]);
            end
            default: begin
                opa_next = 24'(prog); opb_next = 24'sd1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (setup) begin
            mode_q  <= mode;
            add_reg <= add_next;
            opa_reg <= opa_next;
            opb_reg <= opb_next;
        end
        if (mul) prod_reg <= opa_reg * opb_reg;
        if (finish) eased_reg <= eased_comb;
    end

    always_comb begin
        num = '0;
        rnd = '0;
        q = '0;
        val = '0;
        eased_comb = '0;
        case (mode_q) inside
            MODE_IN, MODE_OUT: begin
                num = 73'(prod_reg) + (73'd1 << 17);
                rnd = 74'(num >> 18);
            end
            MODE_INOUT: begin
                if (prog < 17'd32768) num = 73'(prod_reg) + (73'd1 << 17);
                else num = 73'(prod_reg) - (73'd1 << 32) + (73'd1 << 17);
                rnd = 74'(num >> 18);
            end
            MODE_BOUNCE: begin
                num = (last_piece ? 73'(prod_reg) : 73'(prod_reg) << 2)
                      + 73'(add_reg) + (73'd1 << 23);
                rnd = 74'(num >> 24);
            end
            MODE_ELASTIC: begin
                q = ((73'(prod_reg) + 73'sd65536 + (73'sd1 <<< 40)) >>> 17)
                    - (73'sd1 <<< 23);
                val = 73'sd16384 + q;
                if (is_zero) val = 73'sd0;
                else if (is_one) val = 73'sd16384;
                rnd = (val < 0) ? 74'd0 : 74'(val);
            end
            default: begin
                num = 73'(prog) + 73'd2;
                rnd = 74'(num >> 2);
            end
        endcase
        eased_comb = (rnd > 74'd65535) ? 16'hFFFF : rnd[15:0];
    end

    assign eased = eased_reg;
endmodule

@@ src/eased_tween_generator_top.sv @@
// ----------------------------------------------------------------------------
// eased_tween_generator_top: tween timer with easing curves
// Elapsed time, restoring divider and shared curve multiplier.
// ----------------------------------------------------------------------------
// A request passes through these steps before the next one is accepted:
// accumulate, progress on the one-bit-per-cycle divider (16 quotient bits and
// the handoff), table setup, one multiply on the shared multiplier, rounding,
// the output state and the return to idle. When progress is already complete
// the divider is skipped. s_tready is low while a request is in work; the
// result waits in m_tdata until taken. Configuration writes are taken anytime.
module eased_tween_generator_top #(
    parameter int TABLE_DEPTH = 256,
    parameter int TIME_WIDTH  = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // tick_delta[15:0]
    input  logic        s_tuser,   // restart
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // eased_value[15:0], progress[32:16], done_res[33]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import etg_pkg::*;

    // sum width: holds elapsed plus a 16-bit delta and the 16-bit duration
    localparam int SW = ((TIME_WIDTH > 16) ? TIME_WIDTH : 16) + 1;
    localparam logic [SW-1:0] TIME_MAX = SW'((64'd1 << TIME_WIDTH) - 64'd1);

    seq_state_t state_reg, state_next;
    logic [15:0] dur_reg;
    logic [2:0]  mode_reg;
    logic [TIME_WIDTH-1:0] elapsed_reg;
    logic [15:0] delta_reg;
    logic        restart_reg;
    logic [16:0] prog_reg;
    logic [SW-1:0] acc, cap;
    logic        acc_full;
    logic div_start, div_busy;
    logic [15:0] quo;
    logic [15:0] eased;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = (state_reg == ST_OUT);
    assign m_tdata   = {6'd0, prog_reg[16], prog_reg, eased};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dur_reg  <= 16'd1;
            mode_reg <= '0;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_DURATION) dur_reg <= cfg_data;
            else mode_reg <= cfg_data[2:0];
        end
    end

    always_comb begin
        cap = (SW'(dur_reg) < TIME_MAX) ? SW'(dur_reg) : TIME_MAX;
        acc = (restart_reg ? SW'(0) : SW'(elapsed_reg)) + SW'(delta_reg);
        if (acc > cap) acc = cap;
        acc_full = (dur_reg == 16'd0) || (acc >= SW'(dur_reg));
    end

    etg_divider #(.TIME_WIDTH(TIME_WIDTH)) u_div (
        .aclk, .aresetn, .start(div_start), .num(acc[TIME_WIDTH-1:0]),
        .den(dur_reg), .busy(div_busy), .quo
    );

    etg_curve #(.TABLE_DEPTH(TABLE_DEPTH)) u_curve (
        .aclk, .setup(state_reg == ST_SETUP), .mul(state_reg == ST_MUL),
        .finish(state_reg == ST_FINISH), .mode(mode_reg), .prog(prog_reg),
        .eased
    );

    always_comb begin
        state_next = state_reg;
        div_start  = 1'b0;
        unique case (state_reg)
            ST_IDLE:   if (s_tvalid) state_next = ST_ACCUM;
            ST_ACCUM: begin
                if (acc_full) begin
                    state_next = ST_SETUP;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:    if (!div_busy) state_next = ST_SETUP;
            ST_SETUP:  state_next = ST_MUL;
            ST_MUL:    state_next = ST_FINISH;
            ST_FINISH: state_next = ST_OUT;
            ST_OUT:    if (m_tready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            elapsed_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_ACCUM) begin
                elapsed_reg <= acc[TIME_WIDTH-1:0];
                if (acc_full) prog_reg <= 17'h10000;
            end
            if (state_reg == ST_DIV && !div_busy)
                prog_reg <= {1'b0, quo};
        end
        if (s_tvalid && s_tready) begin
            delta_reg   <= s_tdata;
            restart_reg <= s_tuser;
        end
    end
endmodule

@@ src/etg_checker.sv @@
// ----------------------------------------------------------------------------
// etg_checker: port-level checks of the tween generator
// Sequencing of requests and results as seen on the ports.
// ----------------------------------------------------------------------------
module etg_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("input taken with result pending");
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready) else $error("ready after request");
    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[33] == m_tdata[32])) else $error("done mismatch");
    a_prog: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[32]) |-> (m_tdata[31:16] == 16'd0))
        else $error("progress above one");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");
endmodule

bind eased_tween_generator_top etg_checker u_chk (
    .aclk, .aresetn, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata
);

@@ bench/eased_tween_generator_top_tb.sv @@
// ----------------------------------------------------------------------------
// eased_tween_generator_top_tb: self-checking bench for the tween generator
// Streams tick requests through phases of config, source idling and sink stalls,
// predicts each result from an in-bench model of elapsed time and the curves, and compares.
// ----------------------------------------------------------------------------
module eased_tween_generator_top_tb;
    import etg_pkg::*;

    typedef struct packed {
        logic        restart;
        logic [15:0] delta;
    } tick_req_t;

    typedef struct packed {
        logic [15:0] eased;
        logic [16:0] prog;
        logic        done;
    } tween_res_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    eased_tween_generator_top dut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    tick_req_t  pending_ticks[$];
    tween_res_t expected_res[$];
    tick_req_t  cur_tick;
    int         src_idle_pct = 0;
    int         sink_stall_pct = 0;
    int         errs = 0;
    int         quiet_cycles = 0;

    // bench copy of the block state
    logic [15:0] dur_q = 16'd1;
    logic [2:0]  mode_q = MODE_LINEAR;
    logic [15:0] elapsed_q = '0;
    longint      sine_tbl[256];
    longint      decay_tbl[256];

    function automatic longint unsigned round_q14(longint unsigned num, int sh);
        longint unsigned v;
        v = (num + (64'd1 << (sh - 1))) >> sh;
        return (v > 65535) ? 65535 : v;
    endfunction

    function automatic logic [15:0] ease_curve(longint unsigned p);
        longint e, dd, amp, prod, q, val;
        longint unsigned tenp, ph;
        int k, ei, si;
        case (mode_q)
            MODE_IN:  return 16'(round_q14(p * p, 18));
            MODE_OUT: return 16'(round_q14(((2 * p) << 16) - p * p, 18));
            MODE_INOUT: begin
                if (p < 32768) return 16'(round_q14(2 * p * p, 18));
                return 16'(round_q14(((4 * p) << 16) - 2 * p * p - (64'd1 << 32), 18));
            end
            MODE_BOUNCE: begin
                e = 11 * longint'(p);
                if (e < 4 * 65536) return 16'(round_q14(4 * e * e, 24));
                if (e < 8 * 65536) begin
                    dd = e - 6 * 65536;
                    return 16'(round_q14(4 * dd * dd + (64'd3 << 36), 24));
                end
                if (e < 10 * 65536) begin
                    dd = e - 9 * 65536;
                    return 16'(round_q14(4 * dd * dd + (64'd15 << 34), 24));
                end
                dd = 2 * e - 21 * 65536;
                return 16'(round_q14(dd * dd + (64'd63 << 32), 24));
            end
            MODE_ELASTIC: begin
                if (p == 0) return 16'd0;
                if (p >= 65536) return 16'd16384;
                tenp = 10 * p;
                k = int'(tenp >> 16);
                ei = int'(((tenp & 64'hFFFF) * 256) >> 16);
                amp = decay_tbl[ei] >>> k;
                ph = 40 * p + 589824;
                si = int'(((ph * 256) / 786432) % 256);
                prod = amp * sine_tbl[si];
                q = (prod + 65536 + (64'sd1 <<< 40)) / (64'sd1 <<< 17) - (64'sd1 <<< 23);
                val = 16384 + q;
                if (val < 0) val = 0;
                if (val > 65535) val = 65535;
                return 16'(val);
            end
            default: return 16'(round_q14(p, 2));
        endcase
    endfunction

    function automatic tween_res_t advance_tween(tick_req_t t);
        tween_res_t r;
        longint unsigned acc, prog;
        acc = t.restart ? 0 : elapsed_q;
        acc += t.delta;
        if (acc > dur_q) acc = dur_q;
        elapsed_q = 16'(acc);
        if (dur_q == 0 || elapsed_q >= dur_q) prog = 65536;
        else prog = (longint'(elapsed_q) << 16) / dur_q;
        r.eased = ease_curve(prog);
        r.prog = 17'(prog);
        r.done = (prog == 65536);
        return r;
    endfunction

    // tables in Q.28 series, same integer recipe as the hardware ROM
    initial begin
        longint unsigned x, term, mag, y;
        longint sum;
        bit neg;
        for (int i = 0; i < 256; i++) begin
            x = (2 * 64'd843314857 * i + 128) / 256;
            neg = 0;
            if (x > 64'd843314857) begin
                x -= 64'd843314857;
                neg = 1;
            end
            sum = x;
            term = x;
            for (int n = 1; n <= 12; n++) begin
                term = ((term * x) >> 28) / (2 * n);
                term = ((term * x) >> 28) / (2 * n + 1);
                if (n % 2) sum -= term; else sum += term;
            end
            if (sum < 0) sum = 0;
            mag = (sum + 4096) >> 13;
            if (mag > 32767) mag = 32767;
            sine_tbl[i] = neg ? -longint'(mag) : longint'(mag);
            y = (64'd186065280 * i) / 256;
            term = 64'd1 << 28;
            sum = term;
            for (int n = 1; n <= 16; n++) begin
                term = ((term * y) >> 28) / n;
                if (n % 2) sum -= term; else sum += term;
            end
            if (sum < 0) sum = 0;
            decay_tbl[i] = (sum + 2048) >> 12;
        end
    end

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) expected_res = {expected_res, advance_tween(cur_tick)};
            if (!s_tvalid || s_tready) begin
                if (pending_ticks.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                    cur_tick = pending_ticks.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= cur_tick.delta;
                    s_tuser <= cur_tick.restart;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        tween_res_t got, want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.eased = m_tdata[15:0];
                got.prog = m_tdata[32:16];
                got.done = m_tdata[33];
                if (expected_res.size() == 0) begin
                    errs++;
                    $display("%0t: unexpected result %h", $time, m_tdata);
                end else begin
                    want = expected_res.pop_front();
                    if (got.eased !== want.eased) begin
                        errs++;
                        $display("%0t: eased exp %0d got %0d", $time, want.eased, got.eased);
                    end
                    if (got.prog !== want.prog) begin
                        errs++;
                        $display("%0t: progress exp %0d got %0d", $time, want.prog, got.prog);
                    end
                    if (got.done !== want.done) begin
                        errs++;
                        $display("%0t: done exp %0d got %0d", $time, want.done, got.done);
                    end
                end
            end
        end
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // watchdog on stalled traffic
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 20000) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic [0:0] idx, logic [15:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_DURATION) dur_q = val;
        else mode_q = val[2:0];
    endtask

    task automatic drain();
        while (pending_ticks.size() > 0 || expected_res.size() > 0 || s_tvalid)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic queue_tick(logic restart, logic [15:0] delta);
        tick_req_t t;
        t.restart = restart;
        t.delta = delta;
        pending_ticks = {pending_ticks, t};
    endtask

    task automatic queue_random(int n, logic [15:0] dur);
        tick_req_t t;
        for (int i = 0; i < n; i++) begin
            t.restart = ($urandom_range(9) == 0);
            if ($urandom_range(9) == 0) t.delta = 16'($urandom());
            else t.delta = 16'($urandom_range(0, dur / 6 + 1));
            pending_ticks = {pending_ticks, t};
        end
    endtask

    initial begin
        logic [15:0] durs[8];
        logic [15:0] dur;
        durs = '{16'd0, 16'd1, 16'd65535, 16'd1000, 16'd37, 16'd300, 16'd5000, 16'd12};
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // reset config: duration one tick, linear
        queue_tick(1'b1, 16'd0);
        queue_tick(1'b0, 16'd0);
        queue_tick(1'b0, 16'd1);
        queue_tick(1'b1, 16'd65535);
        drain();
        write_reg(CFG_DURATION, 16'd1000);
        for (int m = 0; m < 8; m++) begin
            write_reg(CFG_MODE, 16'(m));
            queue_tick(1'b1, 16'd0);
            queue_tick(1'b0, 16'd500);
            queue_tick(1'b0, 16'd499);
            queue_tick(1'b0, 16'd65535);
            drain();
        end
        for (int ph = 0; ph < 16; ph++) begin
            case (ph % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 84; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 84; end
                default: begin src_idle_pct = 26; sink_stall_pct = 26; end
            endcase
            dur = (ph < 8) ? durs[ph] : 16'($urandom_range(2, 3000));
            write_reg(CFG_DURATION, dur);
            write_reg(CFG_MODE, 16'((ph % 3 == 0) ? MODE_ELASTIC : $urandom_range(0, 7)));
            queue_random(120, dur);
            drain();
        end
        if (errs == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
